@@ hw/rtl/spcr_pkg.sv @@
package spcr_pkg;

	localparam int N_OPND = 7;

	typedef enum logic [6:0] {
		CMD_NONE  = 7'b0000001,
		CMD_MOVE  = 7'b0000010,
		CMD_LINE  = 7'b0000100,
		CMD_HOR   = 7'b0001000,
		CMD_VER   = 7'b0010000,
		CMD_CUBIC = 7'b0100000,
		CMD_ARC   = 7'b1000000
	} cmd_t;

	typedef enum logic [2:0] {
		JOB_MOVE  = 3'd0,
		JOB_LINE  = 3'd1,
		JOB_HOR   = 3'd2,
		JOB_VER   = 3'd3,
		JOB_CUBIC = 3'd4,
		JOB_ARC   = 3'd5,
		JOB_CLOSE = 3'd6
	} job_kind_t;

	localparam logic [2:0] SEG_MOVE  = 3'd0;
	localparam logic [2:0] SEG_LINE  = 3'd1;
	localparam logic [2:0] SEG_CUBIC = 3'd2;
	localparam logic [2:0] SEG_ARC   = 3'd3;
	localparam logic [2:0] SEG_CLOSE = 3'd4;

	localparam logic [7:0] LTR_M = 8'h4D;
	localparam logic [7:0] LTR_L = 8'h4C;
	localparam logic [7:0] LTR_H = 8'h48;
	localparam logic [7:0] LTR_V = 8'h56;
	localparam logic [7:0] LTR_C = 8'h43;
	localparam logic [7:0] LTR_A = 8'h41;
	localparam logic [7:0] LTR_Z = 8'h5A;
	localparam logic [7:0] LTR_LOW_A = 8'h61;
	localparam logic [7:0] LTR_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	typedef struct packed {
		job_kind_t kind;
		logic rel;
		logic clear;
		logic [N_OPND-1:0][31:0] opnd;
	} job_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [31:0] ctrl1_x;
		logic [31:0] ctrl1_y;
		logic [31:0] ctrl2_x;
		logic [31:0] ctrl2_y;
		logic [31:0] end_x;
		logic [31:0] end_y;
		logic [31:0] radius_x;
		logic [31:0] radius_y;
		logic [31:0] rotation;
		logic large_arc;
		logic sweep;
	} seg_t;

endpackage

@@ hw/rtl/svg_path_command_resolver.sv @@
// svg path command resolver
// input channel s_*: one path token per word. s_tuser[0] tells a command
// letter (1) from a number (0); s_tuser[1] starts a new path and clears the
// current point, subpath start and active command before the token acts.
// output channel m_*: one absolute segment per completed operand group or
// closepath; m_tuser carries the segment kind, m_tdata the coordinates.
// a front stage decodes letters and collects operands, a two-entry job queue
// sits between it and the back stage that applies relative offsets with
// saturation and holds the current point.
// throughput: one token per cycle while the queue is not full. a completed
// group goes through the queue into the output register behind m_tvalid;
// the current point updates on each pop, so segments leave at one per
// cycle while m_tready is high. when m_tready is low the output register
// holds its word, the queue fills and s_tready drops once both queue
// entries are taken; nothing is lost. after reset no command is active,
// the current point and start are zero and both channels are empty.
module svg_path_command_resolver #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [39:0] s_tdata,   // letter[7:0], value[39:8]
	input  logic [1:0] s_tuser,    // command[0], first_of_path[1]
	output logic m_tvalid,
	input  logic m_tready,
	// ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, radius_x, radius_y,
	// rotation (32 each from bit 0), large_arc[288], sweep[289], zero pad
	output logic [295:0] m_tdata,
	output logic [2:0] m_tuser     // segment_kind[2:0]
);

	spcr_pkg::job_t fjob, bjob;
	spcr_pkg::seg_t seg;
	logic push, q_full, q_valid, pop;

	spcr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.tok_valid(s_tvalid),
		.tok_ready(s_tready),
		.command(s_tuser[0]),
		.letter(s_tdata[7:0]),
		.value(s_tdata[39:8]),
		.first_of_path(s_tuser[1]),
		.q_full(q_full),
		.push(push),
		.job(fjob)
	);

	spcr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(fjob),
		.full(q_full),
		.pop(pop),
		.valid(q_valid),
		.pop_job(bjob)
	);

	spcr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(q_valid),
		.job(bjob),
		.pop(pop),
		.seg_valid(m_tvalid),
		.seg_ready(m_tready),
		.seg(seg)
	);

	assign m_tuser = seg.kind;
	assign m_tdata = {6'b0, seg.sweep, seg.large_arc, seg.rotation, seg.radius_y,
		seg.radius_x, seg.end_y, seg.end_x, seg.ctrl2_y, seg.ctrl2_x,
		seg.ctrl1_y, seg.ctrl1_x};

endmodule

@@ hw/rtl/spcr_front.sv @@
module spcr_front #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic tok_valid,
	output logic tok_ready,
	input  logic command,
	input  logic [7:0] letter,
	input  logic signed [31:0] value,
	input  logic first_of_path,
	input  logic q_full,
	output logic push,
	output spcr_pkg::job_t job
);

	localparam int SH = (COORD_BITS >= 32) ? 31 : COORD_BITS - 1;
	localparam logic signed [31:0] LIM_HI = 32'sh7fffffff >>> (31 - SH);
	localparam logic signed [31:0] LIM_LO = ~LIM_HI;

	spcr_pkg::cmd_t act_q, act, act_n;
	logic rel_q, rel, rel_n;
	logic am_q, am, am_n;
	logic pend_q;
	logic [2:0] cnt_q, cnt, cnt_n;
	logic [31:0] buf_q [spcr_pkg::N_OPND];
	logic tok_acc, clear, lower, buf_we;
	logic [7:0] up;
	logic signed [31:0] vclamp;

	function automatic logic [2:0] group_len(spcr_pkg::cmd_t c);
		logic [2:0] n;
		unique case (c)
			spcr_pkg::CMD_MOVE, spcr_pkg::CMD_LINE: n = 3'd2;
			spcr_pkg::CMD_HOR, spcr_pkg::CMD_VER: n = 3'd1;
			spcr_pkg::CMD_CUBIC: n = 3'd6;
			spcr_pkg::CMD_ARC: n = 3'd7;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	assign tok_ready = !q_full;
	assign tok_acc = tok_valid && tok_ready;
	assign clear = tok_acc && first_of_path;
	assign lower = (letter >= spcr_pkg::LTR_LOW_A) && (letter <= spcr_pkg::LTR_LOW_Z);
	assign up = lower ? letter - spcr_pkg::CASE_OFFSET : letter;

	always_comb begin
		if (value > LIM_HI) begin
			vclamp = LIM_HI;
		end else if (value < LIM_LO) begin
			vclamp = LIM_LO;
		end else begin
			vclamp = value;
		end
	end

	always_comb begin
		act = clear ? spcr_pkg::CMD_NONE : act_q;
		rel = clear ? 1'b0 : rel_q;
		am = clear ? 1'b0 : am_q;
		cnt = clear ? 3'd0 : cnt_q;
		act_n = act;
		rel_n = rel;
		am_n = am;
		cnt_n = cnt;
		push = 1'b0;
		buf_we = 1'b0;
		job.kind = spcr_pkg::JOB_CLOSE;
		job.rel = rel;
		job.clear = pend_q || clear;
		for (int i = 0; i < spcr_pkg::N_OPND; i++) begin
			job.opnd[i] = (3'(i) == cnt) ? vclamp : buf_q[i];
		end
		if (tok_acc) begin
			if (command) begin
				cnt_n = 3'd0;
				am_n = 1'b0;
				rel_n = lower;
				unique case (up)
					spcr_pkg::LTR_M: begin
						act_n = spcr_pkg::CMD_MOVE;
						am_n = 1'b1;
					end
					spcr_pkg::LTR_L: act_n = spcr_pkg::CMD_LINE;
					spcr_pkg::LTR_H: act_n = spcr_pkg::CMD_HOR;
					spcr_pkg::LTR_V: act_n = spcr_pkg::CMD_VER;
					spcr_pkg::LTR_C: act_n = spcr_pkg::CMD_CUBIC;
					spcr_pkg::LTR_A: act_n = spcr_pkg::CMD_ARC;
					spcr_pkg::LTR_Z: begin
						act_n = spcr_pkg::CMD_NONE;
						push = 1'b1;
						job.kind = spcr_pkg::JOB_CLOSE;
					end
					default: begin
						act_n = spcr_pkg::CMD_NONE;
						rel_n = 1'b0;
					end
				endcase
			end else if (act != spcr_pkg::CMD_NONE) begin
				buf_we = 1'b1;
				if (cnt + 3'd1 == group_len(act)) begin
					push = 1'b1;
					cnt_n = 3'd0;
					unique case (act)
						spcr_pkg::CMD_MOVE: begin
							job.kind = am ? spcr_pkg::JOB_MOVE : spcr_pkg::JOB_LINE;
							am_n = 1'b0;
						end
						spcr_pkg::CMD_LINE: job.kind = spcr_pkg::JOB_LINE;
						spcr_pkg::CMD_HOR: job.kind = spcr_pkg::JOB_HOR;
						spcr_pkg::CMD_VER: job.kind = spcr_pkg::JOB_VER;
						spcr_pkg::CMD_CUBIC: job.kind = spcr_pkg::JOB_CUBIC;
						default: job.kind = spcr_pkg::JOB_ARC;
					endcase
				end else begin
					cnt_n = cnt + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= spcr_pkg::CMD_NONE;
			rel_q <= 1'b0;
			am_q <= 1'b0;
			cnt_q <= 3'd0;
			pend_q <= 1'b0;
		end else begin
			act_q <= act_n;
			rel_q <= rel_n;
			am_q <= am_n;
			cnt_q <= cnt_n;
			pend_q <= push ? 1'b0 : (pend_q || clear);
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_q[cnt] <= vclamp;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < 3'd7)
		else $error("operand count out of range");

	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q == spcr_pkg::CMD_NONE) |-> (cnt_q == 3'd0))
		else $error("operands pending with no active command");

endmodule

@@ hw/rtl/spcr_queue.sv @@
module spcr_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  spcr_pkg::job_t push_job,
	output logic full,
	input  logic pop,
	output logic valid,
	output spcr_pkg::job_t pop_job
);

	localparam int DEPTH = 2;
	localparam int PW = $clog2(DEPTH);

	spcr_pkg::job_t ent_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;

	assign full = (cnt_q == (PW + 1)'(DEPTH));
	assign valid = (cnt_q != '0);
	assign pop_job = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !valid))
		else $error("queue underflow");

endmodule

@@ hw/rtl/spcr_back.sv @@
module spcr_back #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  spcr_pkg::job_t job,
	output logic pop,
	output logic seg_valid,
	input  logic seg_ready,
	output spcr_pkg::seg_t seg
);

	localparam int CB = COORD_BITS;

	typedef logic signed [CB-1:0] coord_t;

	localparam coord_t CMAX = {1'b0, {(CB - 1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CB - 1){1'b0}}};

	function automatic coord_t sat_add(coord_t a, coord_t b);
		logic signed [CB:0] s;
		s = (CB + 1)'(a) + (CB + 1)'(b);
		if (s[CB] != s[CB-1]) begin
			return s[CB] ? CMIN : CMAX;
		end
		return s[CB-1:0];
	endfunction

	function automatic coord_t rel_add(coord_t v, coord_t c, logic rel);
		return rel ? sat_add(v, c) : v;
	endfunction

	function automatic coord_t ext(logic signed [31:0] v);
		return CB'(v);
	endfunction

	function automatic logic [31:0] w32(coord_t v);
		return 32'(v);
	endfunction

	coord_t cur_x_q, cur_y_q, start_x_q, start_y_q;
	coord_t cx, cy, sx, sy, ex, ey;
	coord_t o [spcr_pkg::N_OPND];
	coord_t ax0, ay1, ax2, ay3, ax4, ay5, ax5, ay6;
	logic seg_valid_q;
	logic set_start;
	spcr_pkg::seg_t seg_q, seg_n;

	assign pop = job_valid && (!seg_valid_q || seg_ready);
	assign seg_valid = seg_valid_q;
	assign seg = seg_q;

	always_comb begin
		for (int i = 0; i < spcr_pkg::N_OPND; i++) begin
			o[i] = ext(job.opnd[i]);
		end
		cx = job.clear ? '0 : cur_x_q;
		cy = job.clear ? '0 : cur_y_q;
		sx = job.clear ? '0 : start_x_q;
		sy = job.clear ? '0 : start_y_q;
		ax0 = rel_add(o[0], cx, job.rel);
		ay1 = rel_add(o[1], cy, job.rel);
		ax2 = rel_add(o[2], cx, job.rel);
		ay3 = rel_add(o[3], cy, job.rel);
		ax4 = rel_add(o[4], cx, job.rel);
		ay5 = rel_add(o[5], cy, job.rel);
		ax5 = rel_add(o[5], cx, job.rel);
		ay6 = rel_add(o[6], cy, job.rel);
	end

	always_comb begin
		seg_n = '0;
		set_start = 1'b0;
		ex = ax0;
		ey = ay1;
		unique case (job.kind)
			spcr_pkg::JOB_MOVE: begin
				seg_n.kind = spcr_pkg::SEG_MOVE;
				set_start = 1'b1;
			end
			spcr_pkg::JOB_LINE: seg_n.kind = spcr_pkg::SEG_LINE;
			spcr_pkg::JOB_HOR: begin
				seg_n.kind = spcr_pkg::SEG_LINE;
				ey = cy;
			end
			spcr_pkg::JOB_VER: begin
				seg_n.kind = spcr_pkg::SEG_LINE;
				ex = cx;
				ey = rel_add(o[0], cy, job.rel);
			end
			spcr_pkg::JOB_CUBIC: begin
				seg_n.kind = spcr_pkg::SEG_CUBIC;
				seg_n.ctrl1_x = w32(ax0);
				seg_n.ctrl1_y = w32(ay1);
				seg_n.ctrl2_x = w32(ax2);
				seg_n.ctrl2_y = w32(ay3);
				ex = ax4;
				ey = ay5;
			end
			spcr_pkg::JOB_ARC: begin
				seg_n.kind = spcr_pkg::SEG_ARC;
				seg_n.radius_x = job.opnd[0];
				seg_n.radius_y = job.opnd[1];
				seg_n.rotation = job.opnd[2];
				seg_n.large_arc = (job.opnd[3] != '0);
				seg_n.sweep = (job.opnd[4] != '0);
				ex = ax5;
				ey = ay6;
			end
			default: begin
				seg_n.kind = spcr_pkg::SEG_CLOSE;
				ex = sx;
				ey = sy;
			end
		endcase
		seg_n.end_x = w32(ex);
		seg_n.end_y = w32(ey);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid_q <= 1'b0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
		end else begin
			if (pop) begin
				seg_valid_q <= 1'b1;
				cur_x_q <= ex;
				cur_y_q <= ey;
				start_x_q <= set_start ? ex : sx;
				start_y_q <= set_start ? ey : sy;
			end else if (seg_ready) begin
				seg_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			seg_q <= seg_n;
		end
	end

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> seg_valid)
		else $error("popped job did not reach the output register");

	a_close_home: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && job.kind == spcr_pkg::JOB_CLOSE) |=>
		(cur_x_q == start_x_q && cur_y_q == start_y_q))
		else $error("closepath did not return to subpath start");

endmodule
